### sv/prph_pkg.sv
// shared codes and constants for the pseudo-random probe hash table
package prph_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_LOAD   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam int          KEY_W           = 32;
    localparam int          OFF_W           = 6;
    localparam int          TSIZE_W         = 7;
    localparam logic [6:0]  TABLE_SIZE_RESET = 7'd64;

endpackage

### sv/pseudo_random_probe_hash_table.sv
// top level of the pseudo-random probe hash table
// One item is handled at a time and s_tready is low while it is in work. Insert, search and
// delete first reduce the signed key by the slot count with a bit-serial remainder and a
// floored-sign fix, then walk the probe sequence: the home slot is read and checked, and
// every later probe reads the next offset, adds it to the home slot and subtracts the slot
// count until home + offset is below it (at most once when the offset is already smaller).
// A probe offset load goes straight to the result. All of this runs through one shared
// compare-and-subtract against the slot count, and one slot memory read per probe. The
// result stays on the output until taken. Probe offsets must be loaded before use.
module pseudo_random_probe_hash_table
    import prph_pkg::*;
#(
    parameter int MAX_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // key, value, offset_index, offset_value, zero pad
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // found_value
    output logic [1:0]  m_tuser    // status
);

    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int MW  = $clog2(MAX_SLOTS + 1);
    localparam int RW  = ((MW > OFF_W) ? MW : OFF_W) + 1;
    localparam int OD  = MAX_SLOTS - 1;
    localparam int OIW = (OD > 1) ? $clog2(OD) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_FIX  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_OFF  = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_MOD  = 4'd7;
    localparam logic [3:0] S_RESP = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [TSIZE_W-1:0]   tsize_reg;
    logic [MW-1:0]        m_reg, m_next;
    logic [1:0]           mode_reg, mode_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [KEY_W-1:0]     val_reg, val_next;
    logic [KEY_W-1:0]     mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [MW-1:0]        rem_reg, rem_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [MW-1:0]        home_reg, home_next;
    logic [RW-1:0]        cur_reg, cur_next;
    logic [MW-1:0]        i_reg, i_next;
    logic [1:0]           status_reg, status_next;
    logic [KEY_W-1:0]     found_reg, found_next;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;

    logic [1:0]       in_mode;
    logic [KEY_W-1:0] in_key, in_value;
    logic [OFF_W-1:0] in_oidx, in_oval;
    logic [MW-1:0]    eff_size;
    logic             accept;
    logic             cfg_wr;

    // shared compare-and-subtract against the slot count
    logic [RW-1:0] sub_a, sub_d;
    logic          sub_ge;

    logic [SW-1:0]      slot_idx;
    logic [2*KEY_W-1:0] slot_q;
    logic               slot_we;
    logic [OFF_W-1:0]   off_q;
    logic               off_we;
    logic [MW-1:0]      i_m1;
    logic               slot_busy;
    logic               key_hit;

    assign in_mode  = s_tuser;
    assign in_key   = s_tdata[31:0];
    assign in_value = s_tdata[63:32];
    assign in_oidx  = s_tdata[69:64];
    assign in_oval  = s_tdata[75:70];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESP);
    assign m_tdata  = found_reg;
    assign m_tuser  = status_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32-TSIZE_W){1'b0}}, tsize_reg} : 32'd0;

    always_comb
    begin
        if (tsize_reg < 7'd2)
        begin
            eff_size = MW'(2);
        end
        else if (int'(tsize_reg) > MAX_SLOTS)
        begin
            eff_size = MW'(MAX_SLOTS);
        end
        else
        begin
            eff_size = MW'(tsize_reg);
        end
    end

    assign sub_a  = (state_reg == S_DIV) ? RW'({rem_reg, mag_reg[KEY_W-1]}) : cur_reg;
    assign sub_ge = (sub_a >= RW'(m_reg));
    assign sub_d  = sub_a - RW'(m_reg);

    assign slot_idx  = cur_reg[SW-1:0];
    assign slot_busy = valid_reg[slot_idx];
    assign key_hit   = slot_busy && (slot_q[KEY_W-1:0] == key_reg);
    assign i_m1      = i_reg - 1'b1;

    assign slot_we = (state_reg == S_CHK) && (mode_reg == MODE_INSERT) && !slot_busy;
    assign off_we  = accept && (in_mode == MODE_LOAD) && (int'(in_oidx) < OD);

    prph_ram #(.DEPTH(MAX_SLOTS), .WIDTH(2*KEY_W)) u_slot_ram
    (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_idx),
        .wdata ({val_reg, key_reg}),
        .raddr (slot_idx),
        .rdata (slot_q)
    );

    prph_ram #(.DEPTH(OD), .WIDTH(OFF_W)) u_off_ram
    (
        .clk   (clk),
        .we    (off_we),
        .waddr (OIW'(in_oidx)),
        .wdata (in_oval),
        .raddr (i_m1[OIW-1:0]),
        .rdata (off_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        home_next   = home_reg;
        cur_next    = cur_reg;
        i_next      = i_reg;
        status_next = status_reg;
        found_next  = found_reg;
        valid_next  = valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    m_next      = eff_size;
                    mode_next   = in_mode;
                    key_next    = in_key;
                    val_next    = in_value;
                    neg_next    = in_key[KEY_W-1];
                    mag_next    = in_key[KEY_W-1] ? (KEY_W'(0) - in_key) : in_key;
                    rem_next    = '0;
                    cnt_next    = '0;
                    status_next = ST_OK;
                    found_next  = '0;
                    state_next  = (in_mode == MODE_LOAD) ? S_RESP : S_DIV;
                end
            end
            S_DIV:
            begin
                // one remainder bit per cycle on the key magnitude
                mag_next = {mag_reg[KEY_W-2:0], 1'b0};
                rem_next = sub_ge ? sub_d[MW-1:0] : sub_a[MW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                // floored remainder for negative keys
                if (neg_reg && (rem_reg != '0))
                begin
                    home_next = m_reg - rem_reg;
                end
                else
                begin
                    home_next = rem_reg;
                end
                cur_next   = RW'(home_next);
                i_next     = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if ((mode_reg == MODE_INSERT) && !slot_busy)
                begin
                    valid_next[slot_idx] = 1'b1;
                    state_next           = S_RESP;
                end
                else if ((mode_reg != MODE_INSERT) && key_hit)
                begin
                    if (mode_reg == MODE_SEARCH)
                    begin
                        found_next = slot_q[2*KEY_W-1:KEY_W];
                    end
                    else
                    begin
                        valid_next[slot_idx] = 1'b0;
                    end
                    state_next = S_RESP;
                end
                else if ((i_reg + 1'b1) == m_reg)
                begin
                    status_next = (mode_reg == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_OFF;
                end
            end
            S_OFF:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cur_next   = RW'(home_reg) + RW'(off_q);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (sub_ge)
                begin
                    cur_next = sub_d;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RESP:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            tsize_reg <= TABLE_SIZE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_wr)
            begin
                tsize_reg <= pwdata[TSIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        home_reg   <= home_next;
        cur_reg    <= cur_next;
        i_reg      <= i_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (cur_reg < RW'(m_reg)))
        else $error("probe slot beyond slot count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOT_FOUND || m_tuser == ST_FULL))
        else $error("bad status code");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == 32'd0))
        else $error("value returned on a miss");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (i_reg < m_reg))
        else $error("probe count beyond slot count");
`endif

endmodule

### sv/prph_ram.sv
// simple dual-port memory with registered read
module prph_ram
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### bench/tb.sv
// testbench for the pseudo-random probe hash table, self-checking against its own table copy
`timescale 1ns / 100ps

module tb;
    import prph_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // key, value, offset_index, offset_value, zero pad
    logic [1:0]  s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // found_value
    logic [1:0]  m_tuser;   // status

    localparam logic [2:0] ADDR_TABLE_SIZE = 3'd0;

    // mirror of the table
    bit          slot_used [64];
    logic [31:0] slot_key_m [64];
    logic [31:0] slot_val_m [64];
    logic [5:0]  probe_off [63];
    logic [6:0]  cur_size;

    outcome_t    pending [$];
    logic [31:0] known_keys [$];
    int          mism;
    int          n_items;
    int          n_results;
    int          n_found;
    int          n_full;
    int          burst_left;
    int          hold_cnt;
    int          rx_mode;
    int          rx_left;

    pseudo_random_probe_hash_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 clk = ~clk;

    function automatic int eff_slots();
        if (cur_size < 2) return 2;
        if (cur_size > 64) return 64;
        return cur_size;
    endfunction

    function automatic int home_of(logic [31:0] key, int m);
        longint k;
        longint r;
        k = longint'(signed'(key));
        r = k % m;
        if (r < 0) r += m;
        return int'(r);
    endfunction

    function automatic int probe_at(int home, int i, int m);
        if (i == 0) return home;
        return (home + probe_off[i-1]) % m;
    endfunction

    // first matching slot in probe order, m when none
    function automatic int find_slot(logic [31:0] key, int m);
        int h;
        int s;
        h = home_of(key, m);
        for (int i = 0; i < m; i++)
        begin
            s = probe_at(h, i, m);
            if (slot_used[s] && slot_key_m[s] == key) return s;
        end
        return m;
    endfunction

    function automatic outcome_t apply_op(logic [1:0] mode, logic [31:0] key, logic [31:0] val,
                                          logic [5:0] oi, logic [5:0] ov);
        outcome_t o;
        int m;
        int h;
        int s;
        o = '{status: ST_OK, value: 32'd0};
        m = eff_slots();
        case (mode)
            MODE_INSERT:
            begin
                h = home_of(key, m);
                o.status = ST_FULL;
                for (int i = 0; i < m; i++)
                begin
                    s = probe_at(h, i, m);
                    if (!slot_used[s])
                    begin
                        slot_used[s] = 1;
                        slot_key_m[s] = key;
                        slot_val_m[s] = val;
                        o.status = ST_OK;
                        break;
                    end
                end
            end
            MODE_SEARCH:
            begin
                s = find_slot(key, m);
                if (s < m)
                begin
                    o.value = slot_val_m[s];
                    n_found++;
                end
                else o.status = ST_NOT_FOUND;
            end
            MODE_DELETE:
            begin
                s = find_slot(key, m);
                if (s < m) slot_used[s] = 0;
                else o.status = ST_NOT_FOUND;
            end
            default:
                if (oi < 63) probe_off[oi] = ov;
        endcase
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mism++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_results);
    endtask

    // transaction monitor: results first, then the accepted item
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending.size() == 0)
                    report("unexpected result", {30'd0, m_tuser}, 32'd0);
                else
                begin
                    e = pending.pop_front();
                    if (m_tuser !== e.status) report("status", {30'd0, m_tuser}, {30'd0, e.status});
                    if (m_tdata !== e.value) report("found_value", m_tdata, e.value);
                    if (e.status == ST_FULL) n_full++;
                end
                n_results++;
            end
            if (s_tvalid && s_tready)
            begin
                pending.push_back(apply_op(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                           s_tdata[69:64], s_tdata[75:70]));
                n_items++;
            end
        end
    end

    // receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send(logic [1:0] mode, logic [31:0] key, logic [31:0] val,
                        logic [5:0] oi, logic [5:0] ov);
        @(negedge clk);
        s_tuser  = mode;
        s_tdata  = {4'd0, ov, oi, val, key};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        if (mode == MODE_INSERT && known_keys.size() < 200) known_keys.push_back(key);
        if (burst_left > 0) burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 8);
            if ($urandom_range(0, 2) != 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending.size() == 0);
        repeat (5) @(negedge clk);
    endtask

    task automatic set_size(logic [6:0] sz);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; paddr = ADDR_TABLE_SIZE; pwdata = {25'd0, sz};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        cur_size = sz;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0, 1, 2: return known_keys.size() ? known_keys[$urandom_range(0, known_keys.size()-1)]
                                              : $urandom;
            3: return 32'($signed($urandom_range(0, 400)) - 200);
            default: return $urandom;
        endcase
    endfunction

    // every offset entry must be loaded before any probe can use it
    task automatic test_load_offsets();
        for (int i = 0; i < 63; i++)
            send(MODE_LOAD, $urandom, $urandom, 6'(i), 6'($urandom_range(0, 63)));
        send(MODE_LOAD, 32'd0, 32'd0, 6'd63, 6'd63);   // out of range index, ignored
        drain();
    endtask

    task automatic test_directed();
        send(MODE_INSERT, 32'd0, 32'h7fffffff, 6'd0, 6'd0);
        send(MODE_INSERT, 32'hffffffff, 32'h80000000, 6'd0, 6'd0);
        send(MODE_INSERT, 32'h80000000, 32'h1234, 6'd0, 6'd0);
        send(MODE_INSERT, 32'h7fffffff, 32'hffffffff, 6'd0, 6'd0);
        send(MODE_INSERT, 32'd5, 32'd111, 6'd0, 6'd0);
        send(MODE_INSERT, 32'd5, 32'd222, 6'd0, 6'd0);   // duplicate copy
        send(MODE_SEARCH, 32'd5, 32'd0, 6'd0, 6'd0);
        send(MODE_DELETE, 32'd5, 32'd0, 6'd0, 6'd0);
        send(MODE_SEARCH, 32'd5, 32'd0, 6'd0, 6'd0);     // now the second copy
        send(MODE_SEARCH, 32'hffffffff, 32'd0, 6'd0, 6'd0);
        send(MODE_SEARCH, 32'h80000000, 32'd0, 6'd0, 6'd0);
        send(MODE_SEARCH, 32'd999, 32'd0, 6'd0, 6'd0);
        send(MODE_DELETE, 32'd999, 32'd0, 6'd0, 6'd0);
        drain();
        // shrink while filled, fill up, then grow back
        set_size(7'd2);
        send(MODE_INSERT, 32'd77, 32'd1, 6'd0, 6'd0);
        send(MODE_INSERT, 32'd78, 32'd2, 6'd0, 6'd0);
        send(MODE_INSERT, 32'd79, 32'd3, 6'd0, 6'd0);
        send(MODE_SEARCH, 32'h7fffffff, 32'd0, 6'd0, 6'd0);
        drain();
        set_size(7'd0);
        send(MODE_SEARCH, 32'd78, 32'd0, 6'd0, 6'd0);
        drain();
        set_size(7'd127);
        send(MODE_SEARCH, 32'h7fffffff, 32'd0, 6'd0, 6'd0);
        send(MODE_SEARCH, 32'd77, 32'd0, 6'd0, 6'd0);
        drain();
    endtask

    task automatic test_pressure();
        hold_cnt = 600;
        for (int i = 0; i < 12; i++)
            send(MODE_INSERT, pick_key(), $urandom, 6'd0, 6'd0);
        drain();
    endtask

    task automatic test_random(logic [6:0] sz, int n);
        int r;
        set_size(sz);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40) send(MODE_INSERT, pick_key(), $urandom, $urandom, $urandom);
            else if (r < 70) send(MODE_SEARCH, pick_key(), $urandom, $urandom, $urandom);
            else if (r < 94) send(MODE_DELETE, pick_key(), $urandom, $urandom, $urandom);
            else send(MODE_LOAD, $urandom, $urandom, 6'($urandom), 6'($urandom));
        end
        drain();
    endtask

    initial
    begin
        clk = 0; rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = MODE_INSERT; m_tready = 0;
        mism = 0; n_items = 0; n_results = 0; n_found = 0; n_full = 0;
        burst_left = 0; hold_cnt = 0; rx_mode = 0; rx_left = 0;
        cur_size = TABLE_SIZE_RESET;
        foreach (slot_used[i]) slot_used[i] = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;

        test_load_offsets();
        test_directed();
        test_pressure();
        test_random(7'd64, 160);
        test_random(7'd7, 150);
        test_random(7'd2, 80);
        test_random(7'd1, 40);
        test_random(7'd127, 150);
        test_random(7'($urandom_range(3, 63)), 180);

        repeat (50) @(negedge clk);
        $display("covered %0d operations, %0d results, %0d search hits, %0d full inserts",
                 n_items, n_results, n_found, n_full);
        $display("table sizes 0 to 127 incl. saturation, long output hold-off, %0d mismatches",
                 mism);
        if (mism == 0 && pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### pseudo_random_probe_hash_table.f
sv/prph_pkg.sv
sv/prph_ram.sv
sv/pseudo_random_probe_hash_table.sv
bench/tb.sv
